// File: hdl/u1_lattice_plaquette_engine_unit_macros.svh
// Assertion macros shared by the checker of the U(1) lattice plaquette engine.
// No dependencies; included by hdl/u1lpe_checker.sv.
`ifndef U1_LATTICE_PLAQUETTE_ENGINE_UNIT_MACROS_SVH
`define U1_LATTICE_PLAQUETTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define U1LPE_ASSERT_SAME(label, ck, rst, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define U1LPE_ASSERT_NEXT(label, ck, rst, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/u1lpe_pkg.sv
// Types, constants and helper functions of the U(1) lattice plaquette engine.
// No dependencies; used by u1lpe_cmul, u1_lattice_plaquette_engine_unit and u1lpe_checker.
package u1lpe_pkg;

  localparam int GRID_X     = 16;
  localparam int GRID_Y     = 16;
  localparam int COORD_W    = 4;
  localparam int LINK_COUNT = 2 * GRID_X * GRID_Y;
  localparam int ADDR_W     = $clog2(LINK_COUNT);
  localparam int Q_W        = 16;
  localparam int FRAC       = Q_W - 1;
  // width of a product sum after the Q1.15 shift
  localparam int SAT_IN_W   = 2 * Q_W + 2 - FRAC;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(Q_MAX);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(Q_MIN);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PLAQ  = 2'd1,
    OP_GAUGE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [COORD_W-1:0]     site_x;
    logic [COORD_W-1:0]     site_y;
    logic                   direction;
    logic signed [Q_W-1:0]  link_re;
    logic signed [Q_W-1:0]  link_im;
    logic signed [Q_W-1:0]  g_here_re;
    logic signed [Q_W-1:0]  g_here_im;
    logic signed [Q_W-1:0]  g_right_re;
    logic signed [Q_W-1:0]  g_right_im;
    logic signed [Q_W-1:0]  g_up_re;
    logic signed [Q_W-1:0]  g_up_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  field_value;
    logic                   saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  re;
    logic signed [Q_W-1:0]  im;
  } cplx_t;

  localparam cplx_t LINK_ONE = '{re: Q_MAX, im: '0};

  typedef struct packed {
    logic                   clamped;
    logic signed [Q_W-1:0]  value;
  } sat_t;

  typedef struct packed {
    logic   start;
    logic   conj_b;
    cplx_t  a;
    cplx_t  b;
  } cmul_req_t;

  typedef struct packed {
    logic   valid;
    logic   sat;
    cplx_t  res;
  } cmul_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
    ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6,
    ST_DONE
  } state_t;

  function automatic sat_t sat_q15(input logic signed [SAT_IN_W-1:0] v);
    sat_t r;
    r.clamped = 1'b0;
    if (v > SAT_HI) begin
      r.clamped = 1'b1;
      r.value   = Q_MAX;
    end else if (v < SAT_LO) begin
      r.clamped = 1'b1;
      r.value   = Q_MIN;
    end else begin
      r.value   = v[Q_W-1:0];
    end
    return r;
  endfunction

  // entry = dir + 2*(x + GRID_X*y), optional +1 step in x or y with wrap
  function automatic logic [ADDR_W-1:0] link_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic dir,
                                                  input logic step_x,
                                                  input logic step_y);
    int xi;
    int yi;
    xi = int'(x) % GRID_X;
    yi = int'(y) % GRID_Y;
    if (step_x) xi = (xi == GRID_X - 1) ? 0 : xi + 1;
    if (step_y) yi = (yi == GRID_Y - 1) ? 0 : yi + 1;
    return ADDR_W'(int'(dir) + 2 * (xi + GRID_X * yi));
  endfunction

endpackage

// File: hdl/u1lpe_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module u1lpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/u1lpe_cmul.sv
// Two-stage complex multiplier, Q1.15 in and out, floor rounding and saturation.
// Depends on u1lpe_pkg.
module u1lpe_cmul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u1lpe_pkg::cmul_req_t  req,
  output u1lpe_pkg::cmul_rsp_t  rsp
);

  localparam int OPW  = u1lpe_pkg::Q_W + 1;
  localparam int PPW  = u1lpe_pkg::Q_W + OPW;
  localparam int SUMW = 2 * u1lpe_pkg::Q_W + 2;

  logic signed [u1lpe_pkg::Q_W-1:0] a_re;
  logic signed [u1lpe_pkg::Q_W-1:0] a_im;
  logic signed [OPW-1:0]            b_re;
  logic signed [OPW-1:0]            b_im_raw;
  logic signed [OPW-1:0]            b_im;

  logic signed [PPW-1:0] pp_rr_r, pp_ii_r, pp_ri_r, pp_ir_r;
  logic                  v1_r;
  logic signed [SUMW-1:0] re_sum;
  logic signed [SUMW-1:0] im_sum;
  u1lpe_pkg::sat_t        re_sat;
  u1lpe_pkg::sat_t        im_sat;
  u1lpe_pkg::cplx_t       res_r;
  logic                   sat_r;
  logic                   v2_r;

  assign a_re     = req.a.re;
  assign a_im     = req.a.im;
  assign b_re     = {req.b.re[u1lpe_pkg::Q_W-1], req.b.re};
  assign b_im_raw = {req.b.im[u1lpe_pkg::Q_W-1], req.b.im};
  // conjugate kept one bit wider so -(-1.0) is exact
  assign b_im     = req.conj_b ? -b_im_raw : b_im_raw;

  always_ff @(posedge clk) begin
    pp_rr_r <= a_re * b_re;
    pp_ii_r <= a_im * b_im;
    pp_ri_r <= a_re * b_im;
    pp_ir_r <= a_im * b_re;
  end

  assign re_sum = SUMW'(pp_rr_r) - SUMW'(pp_ii_r);
  assign im_sum = SUMW'(pp_ri_r) + SUMW'(pp_ir_r);
  // arithmetic drop of the fraction bits is floor
  assign re_sat = u1lpe_pkg::sat_q15(re_sum[SUMW-1:u1lpe_pkg::FRAC]);
  assign im_sat = u1lpe_pkg::sat_q15(im_sum[SUMW-1:u1lpe_pkg::FRAC]);

  always_ff @(posedge clk) begin
    res_r.re <= re_sat.value;
    res_r.im <= im_sat.value;
    sat_r    <= re_sat.clamped | im_sat.clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
    end
  end

  assign rsp.valid = v2_r;
  assign rsp.sat   = sat_r;
  assign rsp.res   = res_r;

endmodule

// File: hdl/u1_lattice_plaquette_engine_unit.sv
// U(1) lattice plaquette engine: a 16x16 periodic lattice of Q1.15 complex links
// held in one single-port link RAM, two per site. After reset the block fills
// the RAM with 1+0i (stored as 32767+0i) and stalls its input meanwhile. Items
// are then handled one at a time; the single RAM port and the complex multiplier
// set the pace: a link write passes through ST_WRITE, a gauge transform through
// ST_G0 to ST_G6 and a plaquette through ST_P0 to ST_P8 (four reads, then three
// dependent complex products); code 3 goes to ST_DONE. The result beat sits in
// an output register, so a stalled result only holds back the next result.
// Depends on u1lpe_pkg, u1lpe_ram and u1lpe_cmul.
module u1_lattice_plaquette_engine_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u1lpe_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u1lpe_pkg::out_beat_t  out_data
);

  localparam int AW = u1lpe_pkg::ADDR_W;

  u1lpe_pkg::state_t    state_r, state_nxt;
  u1lpe_pkg::in_beat_t  item_r, item_nxt;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  u1lpe_pkg::cplx_t     a_r, a_nxt;
  u1lpe_pkg::cplx_t     l1_r, l1_nxt;
  u1lpe_pkg::cplx_t     l2_r, l2_nxt;
  logic                 sat_acc_r, sat_acc_nxt;
  logic signed [u1lpe_pkg::Q_W-1:0] field_r, field_nxt;
  logic                 out_valid_r, out_valid_nxt;
  u1lpe_pkg::out_beat_t out_data_r, out_data_nxt;

  logic                 mem_en;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  u1lpe_pkg::cplx_t     mem_wdata;
  logic [$bits(u1lpe_pkg::cplx_t)-1:0] mem_rdata;
  u1lpe_pkg::cplx_t     rd;

  u1lpe_pkg::cmul_req_t req;
  u1lpe_pkg::cmul_rsp_t rsp;

  logic [AW-1:0] addr_ux, addr_uy, addr_uy_right, addr_ux_up, addr_wr;
  u1lpe_pkg::cplx_t gh, gr, gu, wr_val;
  logic signed [u1lpe_pkg::Q_W:0] neg_im;
  u1lpe_pkg::sat_t  neg_sat;

  u1lpe_ram #(
    .WIDTH ($bits(u1lpe_pkg::cplx_t)),
    .DEPTH (u1lpe_pkg::LINK_COUNT)
  ) u_links (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  u1lpe_cmul u_cmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign rd = u1lpe_pkg::cplx_t'(mem_rdata);

  assign addr_ux       = u1lpe_pkg::link_addr(item_r.site_x, item_r.site_y, 1'b0, 1'b0, 1'b0);
  assign addr_uy       = u1lpe_pkg::link_addr(item_r.site_x, item_r.site_y, 1'b1, 1'b0, 1'b0);
  assign addr_uy_right = u1lpe_pkg::link_addr(item_r.site_x, item_r.site_y, 1'b1, 1'b1, 1'b0);
  assign addr_ux_up    = u1lpe_pkg::link_addr(item_r.site_x, item_r.site_y, 1'b0, 1'b0, 1'b1);
  assign addr_wr       = u1lpe_pkg::link_addr(item_r.site_x, item_r.site_y,
                                              item_r.direction, 1'b0, 1'b0);

  assign gh     = '{re: item_r.g_here_re,  im: item_r.g_here_im};
  assign gr     = '{re: item_r.g_right_re, im: item_r.g_right_im};
  assign gu     = '{re: item_r.g_up_re,    im: item_r.g_up_im};
  assign wr_val = '{re: item_r.link_re,    im: item_r.link_im};

  // field is -Im(P); negating -1.0 clamps
  assign neg_im  = -{rsp.res.im[u1lpe_pkg::Q_W-1], rsp.res.im};
  assign neg_sat = u1lpe_pkg::sat_q15(u1lpe_pkg::SAT_IN_W'(neg_im));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= u1lpe_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    a_r        <= a_nxt;
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    sat_acc_r  <= sat_acc_nxt;
    field_r    <= field_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    clr_cnt_nxt   = clr_cnt_r;
    a_nxt         = a_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    sat_acc_nxt   = sat_acc_r | (rsp.valid & rsp.sat);
    field_nxt     = field_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = addr_ux;
    mem_wdata     = rsp.res;
    req           = '0;

    case (state_r)
      u1lpe_pkg::ST_CLEAR: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = u1lpe_pkg::LINK_ONE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(u1lpe_pkg::LINK_COUNT - 1)) state_nxt = u1lpe_pkg::ST_IDLE;
      end
      u1lpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          sat_acc_nxt = 1'b0;
          field_nxt   = '0;
          case (in_data.operation)
            u1lpe_pkg::OP_WRITE: state_nxt = u1lpe_pkg::ST_WRITE;
            u1lpe_pkg::OP_PLAQ:  state_nxt = u1lpe_pkg::ST_P0;
            u1lpe_pkg::OP_GAUGE: state_nxt = u1lpe_pkg::ST_G0;
            default:             state_nxt = u1lpe_pkg::ST_DONE;
          endcase
        end
      end
      u1lpe_pkg::ST_WRITE: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_wr;
        mem_wdata = wr_val;
        state_nxt = u1lpe_pkg::ST_DONE;
      end
      // plaquette: reads back to back, products chained as data arrives
      u1lpe_pkg::ST_P0: begin
        mem_en    = 1'b1;
        mem_addr  = addr_ux;
        state_nxt = u1lpe_pkg::ST_P1;
      end
      u1lpe_pkg::ST_P1: begin
        mem_en    = 1'b1;
        mem_addr  = addr_uy_right;
        a_nxt     = rd;
        state_nxt = u1lpe_pkg::ST_P2;
      end
      u1lpe_pkg::ST_P2: begin
        mem_en    = 1'b1;
        mem_addr  = addr_ux_up;
        req.start = 1'b1;
        req.a     = a_r;
        req.b     = rd;
        state_nxt = u1lpe_pkg::ST_P3;
      end
      u1lpe_pkg::ST_P3: begin
        mem_en    = 1'b1;
        mem_addr  = addr_uy;
        l1_nxt    = rd;
        state_nxt = u1lpe_pkg::ST_P4;
      end
      u1lpe_pkg::ST_P4: begin
        l2_nxt     = rd;
        req.start  = 1'b1;
        req.conj_b = 1'b1;
        req.a      = rsp.res;
        req.b      = l1_r;
        state_nxt  = u1lpe_pkg::ST_P5;
      end
      u1lpe_pkg::ST_P5: state_nxt = u1lpe_pkg::ST_P6;
      u1lpe_pkg::ST_P6: begin
        req.start  = 1'b1;
        req.conj_b = 1'b1;
        req.a      = rsp.res;
        req.b      = l2_r;
        state_nxt  = u1lpe_pkg::ST_P7;
      end
      u1lpe_pkg::ST_P7: state_nxt = u1lpe_pkg::ST_P8;
      u1lpe_pkg::ST_P8: begin
        field_nxt   = neg_sat.value;
        sat_acc_nxt = sat_acc_r | rsp.sat | neg_sat.clamped;
        state_nxt   = u1lpe_pkg::ST_DONE;
      end
      // gauge: both old links read before either is written back
      u1lpe_pkg::ST_G0: begin
        mem_en    = 1'b1;
        mem_addr  = addr_ux;
        state_nxt = u1lpe_pkg::ST_G1;
      end
      u1lpe_pkg::ST_G1: begin
        mem_en    = 1'b1;
        mem_addr  = addr_uy;
        req.start = 1'b1;
        req.a     = gh;
        req.b     = rd;
        state_nxt = u1lpe_pkg::ST_G2;
      end
      u1lpe_pkg::ST_G2: begin
        req.start = 1'b1;
        req.a     = gh;
        req.b     = rd;
        state_nxt = u1lpe_pkg::ST_G3;
      end
      u1lpe_pkg::ST_G3: begin
        req.start  = 1'b1;
        req.conj_b = 1'b1;
        req.a      = rsp.res;
        req.b      = gr;
        state_nxt  = u1lpe_pkg::ST_G4;
      end
      u1lpe_pkg::ST_G4: begin
        req.start  = 1'b1;
        req.conj_b = 1'b1;
        req.a      = rsp.res;
        req.b      = gu;
        state_nxt  = u1lpe_pkg::ST_G5;
      end
      u1lpe_pkg::ST_G5: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_ux;
        mem_wdata = rsp.res;
        state_nxt = u1lpe_pkg::ST_G6;
      end
      u1lpe_pkg::ST_G6: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_uy;
        mem_wdata = rsp.res;
        state_nxt = u1lpe_pkg::ST_DONE;
      end
      u1lpe_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.field_value = field_r;
          out_data_nxt.saturated   = sat_acc_r;
          state_nxt                = u1lpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = u1lpe_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != u1lpe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/u1lpe_checker.sv
// Port-level assertions for u1_lattice_plaquette_engine_unit, bound to the top level.
// Depends on u1lpe_pkg and u1_lattice_plaquette_engine_unit_macros.svh.
`include "u1_lattice_plaquette_engine_unit_macros.svh"

module u1lpe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input u1lpe_pkg::in_beat_t   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input u1lpe_pkg::out_beat_t  out_data
);

  logic in_beat;
  logic out_held;
  assign in_beat  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;

  `U1LPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held,
                     out_valid && $stable(out_data), "stalled result beat changed")
  // one item at a time: busy right after any accepted beat
  `U1LPE_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, in_stall,
                     "input taken while item in flight")
  // a new result only appears as an item finishes
  `U1LPE_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall),
                     "result beat without busy engine")

endmodule

bind u1_lattice_plaquette_engine_unit u1lpe_checker u_checker (.*);
